FILE: hw/rtl/rational_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Widths, operation codes and transaction types shared by the unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int NUM_W        = OPERAND_BITS;
    localparam int DEN_W        = OPERAND_BITS - 1;
    localparam int MAG_W        = 2 * OPERAND_BITS;
    localparam int RES_NUM_W    = 2 * OPERAND_BITS;
    localparam int RES_DEN_W    = 2 * OPERAND_BITS - 1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     operation;
        logic signed [NUM_W-1:0] a_num;
        logic [DEN_W-1:0]        a_den;
        logic signed [NUM_W-1:0] b_num;
        logic [DEN_W-1:0]        b_den;
    } req_t;

    typedef struct packed {
        logic signed [RES_NUM_W-1:0] res_num;
        logic [RES_DEN_W-1:0]        res_den;
        logic                        status;
    } rsp_t;

    typedef struct packed {
        logic [MAG_W-1:0] n_mag;
        logic [MAG_W-1:0] d_mag;
        logic             neg;
        logic             dz;
    } job_t;

endpackage

FILE: hw/rtl/rau_front.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Forms cross products, then sign and magnitudes of numerator and denominator.
// ----------------------------------------------------------------------------
module rau_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rau_pkg::req_t req,
    output logic          job_valid,
    input  logic          job_stall,
    output rau_pkg::job_t job
);

    localparam int PW = rau_pkg::MAG_W;
    localparam int SW = rau_pkg::MAG_W + 1;

    logic                 v_reg;
    rau_pkg::op_t         op_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg;

    logic signed [rau_pkg::NUM_W-1:0] ad_s, bd_s, sel0, sel2;
    logic signed [SW-1:0]             n_s, d_s, n_abs, d_abs;

    assign req_stall = v_reg && job_stall;

    always_comb
    begin
        ad_s = $signed({1'b0, req.a_den});
        bd_s = $signed({1'b0, req.b_den});
        sel0 = (req.operation == rau_pkg::OP_MUL) ? req.b_num : bd_s;
        sel2 = (req.operation == rau_pkg::OP_DIV) ? req.b_num : bd_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            v_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            op_reg <= req.operation;
            p0_reg <= PW'(req.a_num) * PW'(sel0);
            p1_reg <= PW'(req.b_num) * PW'(ad_s);
            p2_reg <= PW'(ad_s) * PW'(sel2);
        end
    end

    always_comb
    begin
        unique case (op_reg)
            rau_pkg::OP_ADD: n_s = SW'(p0_reg) + SW'(p1_reg);
            rau_pkg::OP_SUB: n_s = SW'(p0_reg) - SW'(p1_reg);
            default:         n_s = SW'(p0_reg);
        endcase
        d_s       = SW'(p2_reg);
        n_abs     = n_s[SW-1] ? -n_s : n_s;
        d_abs     = d_s[SW-1] ? -d_s : d_s;
        job.n_mag = n_abs[PW-1:0];
        job.d_mag = d_abs[PW-1:0];
        job.neg   = n_s[SW-1] ^ d_s[SW-1];
        job.dz    = (d_s == '0);
    end

    assign job_valid = v_reg;

endmodule

FILE: hw/rtl/rau_queue.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit job queue
// Two-entry queue between front end and reduction engine.
// ----------------------------------------------------------------------------
module rau_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_stall,
    input  rau_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_stall,
    output rau_pkg::job_t pop_job
);

    logic          head_v_reg, tail_v_reg;
    rau_pkg::job_t head_reg, tail_reg;
    logic          push, pop;

    assign push_stall = tail_v_reg;
    assign push       = push_valid && !tail_v_reg;
    assign pop        = head_v_reg && !pop_stall;
    assign pop_valid  = head_v_reg;
    assign pop_job    = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg <= 1'b0;
            tail_v_reg <= 1'b0;
        end
        else if (pop)
        begin
            head_v_reg <= tail_v_reg || push;
            tail_v_reg <= tail_v_reg && push;
        end
        else if (push)
        begin
            if (!head_v_reg)
            begin
                head_v_reg <= 1'b1;
            end
            else
            begin
                tail_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (tail_v_reg)
            begin
                head_reg <= tail_reg;
                tail_reg <= push_job;
            end
            else
            begin
                head_reg <= push_job;
            end
        end
        else if (push)
        begin
            if (!head_v_reg)
            begin
                head_reg <= push_job;
            end
            else
            begin
                tail_reg <= push_job;
            end
        end
    end

endmodule

FILE: hw/rtl/rau_back.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit reduction engine
// Binary gcd, then shift-subtract division of numerator and denominator.
// ----------------------------------------------------------------------------
module rau_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_stall,
    input  rau_pkg::job_t job,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rau_pkg::rsp_t rsp
);

    localparam int W        = rau_pkg::MAG_W;
    localparam int KW       = $clog2(rau_pkg::MAG_W);
    localparam int CW       = $clog2(rau_pkg::MAG_W);
    localparam int CNT_LAST = rau_pkg::MAG_W - 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GCD,
        S_DIV,
        S_DONE
    } state_t;

    state_t        state_reg;
    logic [W-1:0]  a_reg, b_reg, g_reg;
    logic [KW-1:0] k_reg;
    logic [CW-1:0] cnt_reg;
    logic [W:0]    rn_reg, rd_reg;
    logic [W-1:0]  qn_reg, qd_reg;
    logic          neg_reg, dz_reg;
    logic          rsp_valid_reg;
    rau_pkg::rsp_t rsp_reg;

    logic [W-1:0]  a_next, b_next;
    logic [KW-1:0] k_next;
    logic [W:0]    rn_sh, rd_sh, rn_next, rd_next;
    logic [W-1:0]  qn_next, qd_next, qn_neg;
    logic          out_free;

    assign job_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        if (!a_reg[0] && !b_reg[0])
        begin
            a_next = a_reg >> 1;
            b_next = b_reg >> 1;
            k_next = k_reg + 1'b1;
        end
        else if (!a_reg[0])
        begin
            a_next = a_reg >> 1;
        end
        else if (!b_reg[0])
        begin
            b_next = b_reg >> 1;
        end
        else if (a_reg >= b_reg)
        begin
            a_next = a_reg - b_reg;
        end
        else
        begin
            b_next = b_reg - a_reg;
        end
    end

    always_comb
    begin
        rn_sh   = {rn_reg[W-1:0], qn_reg[W-1]};
        rd_sh   = {rd_reg[W-1:0], qd_reg[W-1]};
        qn_next = {qn_reg[W-2:0], 1'b0};
        qd_next = {qd_reg[W-2:0], 1'b0};
        rn_next = rn_sh;
        rd_next = rd_sh;
        if (rn_sh >= {1'b0, g_reg})
        begin
            rn_next    = rn_sh - {1'b0, g_reg};
            qn_next[0] = 1'b1;
        end
        if (rd_sh >= {1'b0, g_reg})
        begin
            rd_next    = rd_sh - {1'b0, g_reg};
            qd_next[0] = 1'b1;
        end
        qn_neg = -qn_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        a_reg   <= job.n_mag;
                        b_reg   <= job.d_mag;
                        qn_reg  <= job.n_mag;
                        qd_reg  <= job.d_mag;
                        k_reg   <= '0;
                        neg_reg <= job.neg;
                        dz_reg  <= job.dz;
                        state_reg <= job.dz ? S_DONE : S_GCD;
                    end
                end
                S_GCD:
                begin
                    if (a_reg == '0)
                    begin
                        g_reg     <= b_reg << k_reg;
                        rn_reg    <= '0;
                        rd_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        a_reg <= a_next;
                        b_reg <= b_next;
                        k_reg <= k_next;
                    end
                end
                S_DIV:
                begin
                    rn_reg  <= rn_next;
                    rd_reg  <= rd_next;
                    qn_reg  <= qn_next;
                    qd_reg  <= qd_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(CNT_LAST))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        if (dz_reg)
                        begin
                            rsp_reg.res_num <= '0;
                            rsp_reg.res_den <= rau_pkg::RES_DEN_W'(1);
                            rsp_reg.status  <= 1'b1;
                        end
                        else
                        begin
                            rsp_reg.res_num <= $signed(neg_reg ? qn_neg[rau_pkg::RES_NUM_W-1:0]
                                                               : qn_reg[rau_pkg::RES_NUM_W-1:0]);
                            rsp_reg.res_den <= qd_reg[rau_pkg::RES_DEN_W-1:0];
                            rsp_reg.status  <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/rational_arithmetic_unit.sv
// Path: cross products are registered in the front end, pass through the queue, are loaded into the
// engine, then run the binary gcd loop and the division loop before the registered output.
// Flow: the engine takes a new transaction only once idle again; front end and queue hold more.
// Reset: rst_n clears valids, queue and engine state asynchronously.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and returns lowest terms.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rau_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rau_pkg::rsp_t rsp
);

    logic          fj_valid, fj_stall, bj_valid, bj_stall;
    rau_pkg::job_t fj, bj;

    rau_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .job_valid (fj_valid),
        .job_stall (fj_stall),
        .job       (fj)
    );

    rau_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fj_valid),
        .push_stall (fj_stall),
        .push_job   (fj),
        .pop_valid  (bj_valid),
        .pop_stall  (bj_stall),
        .pop_job    (bj)
    );

    rau_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_stall (bj_stall),
        .job       (bj),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    `RAU_ASSERT_IMPLY(a_den_nonzero, rsp_valid, rsp.res_den != '0, "zero result denominator")
    `RAU_ASSERT_IMPLY(a_err_zero, rsp_valid && rsp.status, rsp.res_num == '0 && rsp.res_den == 1, "error result not 0/1")
    `RAU_ASSERT_IMPLY(a_zero_canon, rsp_valid && rsp.res_num == '0, rsp.res_den == 1, "zero result not 0/1")

endmodule
